// File: design/gsk_pkg.sv
// Shared constants, register map and elaboration-time arithmetic for the soft-knee limiter.
package gsk_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned TANH_ENTRIES_DEF = 256;

  localparam int unsigned GAIN_W     = 17;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;

  localparam int unsigned ROM_W    = 31;
  localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
  localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic {
    REG_MASTER_GAIN = 1'b0
  } reg_addr_e;

  // rounded quotient by shift and subtract
  function automatic logic [63:0] div_round(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] n;
    logic [64:0] rem;
    logic [63:0] quo;
    int          i;
    n   = num + (den >> 1);
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + HALF_Q30) >> 30;
  endfunction

endpackage

// File: design/gain_soft_knee_limiter_core.sv
// Gain stage and tanh soft-knee limiter, twelve-stage pipeline with APB gain register.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: sample_in
//  m_axis    out  m_axis_tvalid/tready       tdata: sample_out, tuser: knee_active
//  apb       in   psel/penable/pwrite/pready pwdata[16:0]: master_gain
//
// One sample per cycle unless m_axis_tready holds the output with every stage full.
// Latency is set by the chain of multipliers: gain, table position, correction,
// interpolation and knee scaling, each followed by a register.
// Reset clears the stage valid bits and sets the gain to unity; the table is constant.
// Each stage advances when it is empty or the stage after it advances, so bubbles close
// up and input is taken while a finished result waits.
module gain_soft_knee_limiter_core
  import gsk_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned TANH_ENTRIES = TANH_ENTRIES_DEF,
  parameter int unsigned TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
  output logic               m_axis_tuser,   // [0] knee_active
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned F  = W - 2;
  localparam int unsigned NS = 12;

  localparam logic [63:0] ONE_F = 64'd1 << F;
  localparam logic [63:0] T64   = (64'd85 * ONE_F + 64'd50) / 64'd100;
  localparam logic [63:0] C64   = (64'd98 * ONE_F + 64'd50) / 64'd100;
  localparam logic [63:0] K64   = C64 - T64;
  localparam logic [63:0] D64   = 64'd4 * K64;
  localparam logic [63:0] M64   = 64'(TANH_ENTRIES) << 16;
  localparam logic [63:0] X64   = (M64 << F) / D64;

  localparam int unsigned KW   = $clog2(K64 + 64'd1);
  localparam int unsigned DW4  = $clog2(D64 + 64'd1);
  localparam int unsigned XW   = $clog2(X64 + 64'd1);
  localparam int unsigned NW   = $clog2(TANH_ENTRIES + 1);
  localparam int unsigned P_W  = NW + 16;
  localparam int unsigned PRW  = W + GAIN_W;
  localparam int unsigned QXW  = F + XW;
  localparam int unsigned DMW  = F + NW;
  localparam int unsigned QDW  = P_W + DW4;
  localparam int unsigned CW   = ((DMW + 16) > QDW ? (DMW + 16) : QDW) + 1;
  localparam int unsigned IPW  = ROM_W + 16;
  localparam int unsigned KTW  = KW + ROM_W;

  localparam logic [W-1:0]   T_C    = T64[W-1:0];
  localparam logic [W-1:0]   C_C    = C64[W-1:0];
  localparam logic [W-1:0]   D_C    = D64[W-1:0];
  localparam logic [DW4-1:0] D4_C   = D64[DW4-1:0];
  localparam logic [KW-1:0]  K_C    = K64[KW-1:0];
  localparam logic [XW-1:0]  X_C    = X64[XW-1:0];
  localparam logic [W-1:0]   SIGN_C = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic         neg;
    logic         act;
    logic [W-1:0] mag;
  } side_t;

  logic [GAIN_W-1:0] gain_q;
  logic [GAIN_W-1:0] gain_eff;
  logic [NS-1:0]     v_q;
  logic [NS:0]       en;
  side_t             side_q [NS];
  side_t             side_d [NS];

  logic [W-1:0]       mag0_q;
  logic [PRW-1:0]     prod1_q;
  logic [W-1:0]       d2_q;
  logic [P_W-1:0]     qe3_q;
  logic [F-1:0]       dl3_q;
  logic               sat3_q;
  logic [DMW-1:0]     dm4_q;
  logic [QDW-1:0]     qd4_q;
  logic [P_W-1:0]     qe4_q;
  logic               sat4_q;
  logic [NW-1:0]      idx5_q;
  logic [15:0]        frac5_q;
  logic               sat5_q;
  logic [15:0]        frac6_q;
  logic               sat6_q;
  logic [ROM_W-1:0]   rom_lo;
  logic [ROM_W-1:0]   rom_hi;
  logic [IPW-1:0]     ip7_q;
  logic [ROM_W-1:0]   lo7_q;
  logic               sat7_q;
  logic [ROM_W-1:0]   t8_q;
  logic [KTW-1:0]     kt9_q;
  logic [W-1:0]       out11_q;

  logic [W-1:0]   sample_in;
  logic [W-1:0]   mag0;
  logic [PRW-1:0] sum2;
  logic [W:0]     rnd2;
  logic [W-1:0]   lim2;
  logic [W-1:0]   m2;
  logic [QXW-1:0] qx3;
  logic [CW-1:0]  lhs5;
  logic [CW-1:0]  rhs5;
  logic [P_W-1:0] p5;
  logic [ROM_W-1:0] diff7;
  logic [IPW-1:0] ipr8;
  logic [KTW-1:0] ktr10;
  logic [W-1:0]   mag10;

  // configuration port
  assign pready   = 1'b1;
  assign gain_eff = (gain_q > GAIN_UNITY) ? GAIN_UNITY : gain_q;

  always_comb begin
    case (reg_addr_e'(paddr[2]))
      REG_MASTER_GAIN: prdata = APB_DW'(gain_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_UNITY;
    end else if (psel && penable && pwrite && pready
                 && reg_addr_e'(paddr[2]) == REG_MASTER_GAIN) begin
      gain_q <= pwdata[GAIN_W-1:0];
    end
  end

  // stage enables: advance when empty or when the next stage advances
  always_comb begin
    en[NS] = m_axis_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NS-1];
  assign m_axis_tdata  = TDATA_W'(out11_q);
  assign m_axis_tuser  = side_q[NS-1].act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // datapath
  always_comb begin
    sample_in = s_axis_tdata[W-1:0];
    mag0      = sample_in[W-1] ? (W'(0) - sample_in) : sample_in;

    sum2 = prod1_q + PRW'(32768);
    rnd2 = sum2[PRW-1:16];
    lim2 = side_q[1].neg ? SIGN_C : (SIGN_C - W'(1));
    m2   = (rnd2 > {1'b0, lim2}) ? lim2 : rnd2[W-1:0];

    qx3 = QXW'(d2_q[F-1:0]) * QXW'(X_C);

    lhs5 = CW'({dm4_q, 16'h0000});
    rhs5 = CW'(qd4_q) + CW'(D4_C);
    p5   = qe4_q + P_W'(lhs5 >= rhs5);

    diff7 = (rom_hi < rom_lo) ? '0 : (rom_hi - rom_lo);

    ipr8 = ip7_q + IPW'(32768);

    ktr10 = kt9_q + KTW'(HALF_Q30);
    mag10 = side_q[9].act ? (T_C + W'(ktr10 >> 30)) : side_q[9].mag;

    side_d[0] = '0;
    for (int k = 1; k < NS; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[0].neg = sample_in[W-1];
    side_d[2].act = m2 > T_C;
    side_d[2].mag = m2;
    side_d[10].mag = mag10;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        side_q[k] <= side_d[k];
      end
    end
    if (en[0]) begin
      mag0_q <= mag0;
    end
    if (en[1]) begin
      prod1_q <= PRW'(mag0_q) * PRW'(gain_eff);
    end
    if (en[2]) begin
      d2_q <= m2 - T_C;
    end
    if (en[3]) begin
      qe3_q  <= P_W'(qx3 >> F);
      dl3_q  <= d2_q[F-1:0];
      sat3_q <= d2_q >= D_C;
    end
    if (en[4]) begin
      dm4_q  <= DMW'(dl3_q) * DMW'(TANH_ENTRIES);
      qd4_q  <= QDW'(qe3_q) * QDW'(D4_C);
      qe4_q  <= qe3_q;
      sat4_q <= sat3_q;
    end
    if (en[5]) begin
      idx5_q  <= (sat4_q || !side_q[4].act) ? '0 : p5[P_W-1:16];
      frac5_q <= p5[15:0];
      sat5_q  <= sat4_q;
    end
    if (en[6]) begin
      frac6_q <= frac5_q;
      sat6_q  <= sat5_q;
    end
    if (en[7]) begin
      ip7_q  <= IPW'(diff7) * IPW'(frac6_q);
      lo7_q  <= rom_lo;
      sat7_q <= sat6_q;
    end
    if (en[8]) begin
      t8_q <= sat7_q ? ONE_Q30[ROM_W-1:0] : (lo7_q + ROM_W'(ipr8 >> 16));
    end
    if (en[9]) begin
      kt9_q <= KTW'(K_C) * KTW'(t8_q);
    end
    if (en[11]) begin
      out11_q <= side_q[10].neg ? (W'(0) - side_q[10].mag) : side_q[10].mag;
    end
  end

  gsk_tanh_rom #(
    .TANH_ENTRIES(TANH_ENTRIES),
    .ADDR_W      (NW)
  ) u_rom (
    .clk_i(clk_i),
    .en_i (en[6]),
    .idx_i(idx5_q),
    .lo_o (rom_lo),
    .hi_o (rom_hi)
  );

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> ((&v_q) && !m_axis_tready))
    else $error("input blocked with a free stage");

  a_knee_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-1] && side_q[NS-1].act) |-> (side_q[NS-1].mag >= T_C && side_q[NS-1].mag <= C_C))
    else $error("knee output outside threshold to ceiling");

  a_pass_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-1] && !side_q[NS-1].act) |-> (side_q[NS-1].mag <= T_C))
    else $error("pass-through sample above threshold");

  a_gain_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && reg_addr_e'(paddr[2]) == REG_MASTER_GAIN)
      |=> (gain_q == $past(pwdata[GAIN_W-1:0])))
    else $error("gain register write lost");

endmodule

// File: design/gsk_tanh_rom.sv
// tanh lookup table with two registered read ports at neighbouring entries.
module gsk_tanh_rom
  import gsk_pkg::*;
#(
  parameter int unsigned TANH_ENTRIES = TANH_ENTRIES_DEF,
  parameter int unsigned ADDR_W       = $clog2(TANH_ENTRIES + 1)
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [ADDR_W-1:0] idx_i,
  output logic [ROM_W-1:0]  lo_o,
  output logic [ROM_W-1:0]  hi_o
);

  function automatic logic [TANH_ENTRIES:0][ROM_W-1:0] build_rom();
    logic [63:0] h;
    logic [63:0] h2;
    logic [63:0] h3;
    logic [63:0] h5;
    logic [63:0] h7;
    logic [63:0] th;
    logic [63:0] t;
    logic [63:0] num;
    logic [63:0] den;
    logic [TANH_ENTRIES:0][ROM_W-1:0] rom;
    int          i;
    h  = div_round(64'd4 << 30, 64'(TANH_ENTRIES));
    h2 = q30_mul(h, h);
    h3 = q30_mul(h2, h);
    h5 = q30_mul(h3, h2);
    h7 = q30_mul(h5, h2);
    th = h - div_round(h3, 64'd3) + div_round(64'd2 * h5, 64'd15)
           - div_round(64'd17 * h7, 64'd315);
    t      = '0;
    rom    = '0;
    rom[0] = '0;
    for (i = 0; i < int'(TANH_ENTRIES); i++) begin
      num = (t + th) << 30;
      den = ONE_Q30 + q30_mul(t, th);
      t   = div_round(num, den);
      if (t > ONE_Q30) begin
        t = ONE_Q30;
      end
      rom[i+1] = t[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam logic [TANH_ENTRIES:0][ROM_W-1:0] TANH_ROM = build_rom();

  logic [ADDR_W-1:0] idx_hi;

  assign idx_hi = idx_i + ADDR_W'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_o <= TANH_ROM[idx_i];
      hi_o <= TANH_ROM[idx_hi];
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the gain stage and tanh soft-knee limiter core.
module testbench
  import gsk_pkg::*;
();

  localparam int SW      = SAMPLE_WIDTH_DEF;
  localparam int ENTRIES = TANH_ENTRIES_DEF;
  localparam int FB      = SW - 2;
  localparam int TDATA_W = ((SW + 7) / 8) * 8;

  localparam logic [63:0] THRESH   = (85 * (64'd1 << FB) + 50) / 100;
  localparam logic [63:0] CEILING  = (98 * (64'd1 << FB) + 50) / 100;
  localparam logic [63:0] KNEE     = CEILING - THRESH;
  localparam logic [63:0] SPAN     = 64'd1 << SW;
  localparam logic [63:0] NEG_FULL = 64'd1 << (SW - 1);
  localparam logic [63:0] POS_FULL = NEG_FULL - 1;
  localparam logic [63:0] UNITY    = 64'd65536;

  localparam logic [APB_AW-1:0] GAIN_ADDR = {REG_MASTER_GAIN, 2'b00};
  localparam int unsigned RUN_LIMIT = 200000;

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          knee;
  } limiter_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;   // [SW-1:0] sample_in
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;         // [SW-1:0] sample_out
  logic               m_axis_tuser;         // [0] knee_active
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [APB_AW-1:0]  paddr         = '0;
  logic [APB_DW-1:0]  pwdata        = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  logic [63:0]        tanh_curve [0:ENTRIES];
  logic [GAIN_W-1:0]  gain_setting = GAIN_UNITY;
  limiter_result_t    expected_q [$];
  limiter_result_t    oldest_expected;
  int                 error_count    = 0;
  int unsigned        cycle_count    = 0;
  int unsigned        src_idle_pct   = 0;
  int unsigned        sink_stall_pct = 0;

  gain_soft_knee_limiter_core #(
    .SAMPLE_WIDTH(SW),
    .TANH_ENTRIES(ENTRIES)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [63:0] round_div(input logic [63:0] num, input logic [63:0] den);
    return (num + den / 2) / den;
  endfunction

  function automatic logic [63:0] q30_product(input logic [63:0] a, input logic [63:0] b);
    return (a * b + HALF_Q30) >> 30;
  endfunction

  initial begin : tanh_build
    logic [63:0] step, s2, s3, s5, s7, inc, acc;
    step = round_div(64'd4 << 30, 64'(ENTRIES));
    s2   = q30_product(step, step);
    s3   = q30_product(s2, step);
    s5   = q30_product(s3, s2);
    s7   = q30_product(s5, s2);
    inc  = step - round_div(s3, 64'd3) + round_div(64'd2 * s5, 64'd15)
         - round_div(64'd17 * s7, 64'd315);
    acc  = '0;
    tanh_curve[0] = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      acc = round_div((acc + inc) << 30, ONE_Q30 + q30_product(acc, inc));
      if (acc > ONE_Q30) acc = ONE_Q30;
      tanh_curve[i + 1] = acc;
    end
  end

  function automatic limiter_result_t predict_limiter(input logic [SW-1:0] raw,
                                                      input logic [GAIN_W-1:0] gain);
    logic [63:0]     mag, g, m, pos, idx, frac, lo, hi, t;
    limiter_result_t r;
    mag = raw[SW-1] ? (SPAN - 64'(raw)) : 64'(raw);
    g   = (64'(gain) > UNITY) ? UNITY : 64'(gain);
    m   = (mag * g + 64'd32768) >> 16;
    if (raw[SW-1]) begin
      if (m > NEG_FULL) m = NEG_FULL;
    end else begin
      if (m > POS_FULL) m = POS_FULL;
    end
    r.knee = 1'b0;
    if (m > THRESH) begin
      pos  = ((m - THRESH) * 64'(ENTRIES) * 64'd65536) / (64'd4 * KNEE);
      idx  = pos >> 16;
      frac = pos & 64'hFFFF;
      if (idx >= 64'(ENTRIES)) begin
        t = ONE_Q30;
      end else begin
        lo = tanh_curve[idx];
        hi = tanh_curve[idx + 1];
        if (hi < lo) hi = lo;
        t = lo + (((hi - lo) * frac + 64'd32768) >> 16);
      end
      m      = THRESH + ((KNEE * t + HALF_Q30) >> 30);
      r.knee = 1'b1;
    end
    r.sample = (raw[SW-1] && m != 0) ? SW'(SPAN - m) : SW'(m);
    return r;
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: sample_out %0d knee_active %0b",
               $signed(m_axis_tdata[SW-1:0]), m_axis_tuser);
        error_count++;
      end else begin
        oldest_expected = expected_q.pop_front();
        if (m_axis_tdata[SW-1:0] !== oldest_expected.sample) begin
          $error("sample_out mismatch: expected %0d, actual %0d",
                 $signed(oldest_expected.sample), $signed(m_axis_tdata[SW-1:0]));
          error_count++;
        end
        if (m_axis_tuser !== oldest_expected.knee) begin
          $error("knee_active mismatch: expected %0b, actual %0b",
                 oldest_expected.knee, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [SW-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(value);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_limiter(value, gain_setting));
  endtask

  // drop the request and hold until every result is back
  task automatic settle;
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GAIN_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    gain_setting = value;
  endtask

  task automatic test_reset_unity_knee;
    send_sample('0);
    send_sample(SW'(1));
    send_sample(SW'(SPAN - 1));
    send_sample(SW'(POS_FULL));
    send_sample(SW'(NEG_FULL));
    send_sample(SW'(THRESH));
    send_sample(SW'(THRESH + 1));
    send_sample(SW'(SPAN - THRESH));
    send_sample(SW'(SPAN - THRESH - 1));
    send_sample(SW'(THRESH + 4 * KNEE - 1));
    send_sample(SW'(THRESH + 4 * KNEE));
    send_sample(SW'(SPAN - THRESH - 4 * KNEE));
    send_sample(SW'(64'd1 << FB));
    send_sample(SW'(CEILING));
    settle();
  endtask

  task automatic test_gain_extremes;
    write_gain('0);
    send_sample(SW'(POS_FULL));
    send_sample(SW'(NEG_FULL));
    settle();
    write_gain(GAIN_W'(1));
    send_sample(SW'(NEG_FULL));
    send_sample(SW'(POS_FULL));
    settle();
    write_gain('1);
    send_sample(SW'(POS_FULL));
    send_sample(SW'(SPAN - THRESH - 1));
    settle();
    write_gain(GAIN_W'(32768));
    send_sample(SW'(POS_FULL));
    send_sample(SW'(NEG_FULL));
    settle();
  endtask

  task automatic test_random_traffic;
    int unsigned       src_pct  [4] = '{0, 74, 0, 26};
    int unsigned       sink_pct [4] = '{0, 0, 74, 26};
    logic [GAIN_W-1:0] gain;
    logic [63:0]       mag;
    logic [SW-1:0]     value;
    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 3; s++) begin
        settle();
        case (s)
          0:       gain = GAIN_W'($urandom_range(131071, 0));
          1:       gain = GAIN_W'($urandom_range(65536, 20000));
          default: gain = (p % 2) ? '1 : GAIN_UNITY;
        endcase
        write_gain(gain);
        src_idle_pct   = src_pct[p];
        sink_stall_pct = sink_pct[p];
        for (int n = 0; n < 46; n++) begin
          case ($urandom_range(3))
            0: value = SW'($urandom);
            1: begin
              mag   = THRESH - 64'd2048 + 64'($urandom_range(32'(4 * KNEE + 4096)));
              value = $urandom_range(1) ? SW'(SPAN - mag) : SW'(mag);
            end
            2: begin
              mag   = 64'($urandom_range(65535));
              value = $urandom_range(1) ? SW'(SPAN - mag) : SW'(mag);
            end
            default: value = $urandom_range(1) ? SW'(NEG_FULL + $urandom_range(1023))
                                                : SW'(POS_FULL - $urandom_range(1023));
          endcase
          send_sample(value);
        end
      end
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_unity_knee();
    test_gain_extremes();
    test_random_traffic();
    settle();
    repeat (24) @(posedge clk_i);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: gain_soft_knee_limiter_core.f
design/gsk_pkg.sv
design/gsk_tanh_rom.sv
design/gain_soft_knee_limiter_core.sv
tb/testbench.sv
